### rtl/core/assert_macros.svh
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rlts_pkg.sv
package rlts_pkg;

    // Build defaults
    localparam int NUM_LEDS_DEF   = 18;
    localparam bit ACTIVE_LOW_DEF = 1'b1;

    // led_index is 5 bits, so at most 32 LEDs can ever be serviced
    localparam int IDX_SPAN = 32;
    localparam int OUT_LEDS = 18;

    // Field widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 5;
    localparam int ROLL_W     = 10;
    localparam int ON_W       = 10;
    localparam int REST_W     = 15;
    localparam int THR_W      = 10;
    localparam int MAXLIT_W   = 5;
    localparam int TIME_W     = 16;
    localparam int CNT_W      = 6;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    // Weighted mapping arithmetic
    localparam int PROD_W      = 26;   // signed slope * roll offset
    localparam int MAG_W       = 25;   // magnitude plus rounding bias
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 34;

    localparam logic [ROLL_W-1:0] ROLL_LOW_END    = 10'd400;
    localparam logic [ROLL_W-1:0] ROLL_HIGH_START = 10'd600;
    localparam longint unsigned   DIV_LOW         = 300;
    localparam longint unsigned   DIV_HIGH        = 400;

    // ceil(2^34 / d): exact floor division for every numerator below 2^25
    localparam longint unsigned RECIP_LOW_FULL =
        ((64'd1 << RECIP_SHIFT) + DIV_LOW - 1) / DIV_LOW;
    localparam longint unsigned RECIP_HIGH_FULL =
        ((64'd1 << RECIP_SHIFT) + DIV_HIGH - 1) / DIV_HIGH;
    localparam logic [RECIP_W-1:0] RECIP_LOW  = RECIP_W'(RECIP_LOW_FULL);
    localparam logic [RECIP_W-1:0] RECIP_HIGH = RECIP_W'(RECIP_HIGH_FULL);
    localparam logic [MAG_W-1:0]   BIAS_LOW   = MAG_W'(DIV_LOW - 1);
    localparam logic [MAG_W-1:0]   BIAS_HIGH  = MAG_W'(DIV_HIGH - 1);

    // Time base
    localparam logic [TIME_W-1:0] TIME_RESET   = 16'd60;
    localparam logic [TIME_W-1:0] TIME_RESTART = 16'd10;
    localparam logic [TIME_W-1:0] OVF_BASE     = 16'd65436;

    // Register reset values
    localparam logic [ON_W-1:0]     ON_MIN_RST    = 10'd2;
    localparam logic [ON_W-1:0]     ON_MEAN_RST   = 10'd3;
    localparam logic [ON_W-1:0]     ON_MAX_RST    = 10'd7;
    localparam logic [REST_W-1:0]   REST_MIN_RST  = 15'd50;
    localparam logic [REST_W-1:0]   REST_MEAN_RST = 15'd300;
    localparam logic [REST_W-1:0]   REST_MAX_RST  = 15'd500;
    localparam logic [THR_W-1:0]    TRIG_THR_RST  = 10'd20;
    localparam logic [MAXLIT_W-1:0] MAX_LIT_RST   = 5'd3;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_SERVICE   = 2'd1,
        OP_SWEEP_END = 2'd2,
        OP_UNUSED    = 2'd3
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ON_MIN    = 3'd0,
        REG_ON_MEAN   = 3'd1,
        REG_ON_MAX    = 3'd2,
        REG_REST_MIN  = 3'd3,
        REG_REST_MEAN = 3'd4,
        REG_REST_MAX  = 3'd5,
        REG_TRIG_THR  = 3'd6,
        REG_MAX_LIT   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PIECE_LOW  = 2'd0,
        PIECE_MID  = 2'd1,
        PIECE_HIGH = 2'd2
    } piece_t;

    typedef struct packed {
        logic [ON_W-1:0]     on_min;
        logic [ON_W-1:0]     on_mean;
        logic [ON_W-1:0]     on_max;
        logic [REST_W-1:0]   rest_min;
        logic [REST_W-1:0]   rest_mean;
        logic [REST_W-1:0]   rest_max;
        logic [THR_W-1:0]    trigger_threshold;
        logic [MAXLIT_W-1:0] max_lit;
    } cfg_t;

    // One roll after the multiply: which piece, and slope * offset
    typedef struct packed {
        piece_t                   piece;
        logic signed [PROD_W-1:0] prod;
    } roll_term_t;

    // Input stage contents handed to the state update
    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] led_index;
        logic             trig_ok;
        roll_term_t       on_term;
        roll_term_t       rest_term;
    } item_t;

    // Pick the piece and form slope * offset for a roll
    function automatic roll_term_t weigh_prod(input logic [ROLL_W-1:0] roll,
                                              input logic [REST_W-1:0] lo,
                                              input logic [REST_W-1:0] mid,
                                              input logic [REST_W-1:0] hi);
        roll_term_t                         t;
        logic signed [REST_W+1:0]           diff;
        logic [ROLL_W-1:0]                  offs;
        logic signed [REST_W+ROLL_W+2:0]    full;
        if (roll < ROLL_LOW_END) begin
            t.piece = PIECE_LOW;
            diff    = $signed({2'b00, mid}) - $signed({2'b00, lo});
            offs    = roll;
        end else if (roll > ROLL_HIGH_START) begin
            t.piece = PIECE_HIGH;
            diff    = $signed({2'b00, hi}) - $signed({2'b00, mid});
            offs    = roll - ROLL_HIGH_START;
        end else begin
            t.piece = PIECE_MID;
            diff    = '0;
            offs    = '0;
        end
        full   = diff * $signed({1'b0, offs});
        t.prod = full[PROD_W-1:0];
        return t;
    endfunction

    // Floor-divide the product by the piece's divisor (300 low, 400 high) and add the base, mod 2^16
    function automatic logic [TIME_W-1:0] weigh_len(input roll_term_t t,
                                                    input logic [REST_W-1:0] lo,
                                                    input logic [REST_W-1:0] mid);
        logic                        neg;
        logic [MAG_W-1:0]            mag;
        logic [MAG_W-1:0]            x;
        logic [RECIP_W-1:0]          recip;
        logic [MAG_W+RECIP_W-1:0]    full;
        logic [TIME_W-1:0]           q;
        logic [TIME_W-1:0]           base;
        neg = t.prod[PROD_W-1];
        mag = neg ? MAG_W'(-t.prod) : MAG_W'(t.prod);
        unique case (t.piece)
            PIECE_LOW: begin
                base  = {1'b0, lo};
                recip = RECIP_LOW;
                x     = neg ? mag + BIAS_LOW : mag;
            end
            PIECE_HIGH: begin
                base  = {1'b0, mid};
                recip = RECIP_HIGH;
                x     = neg ? mag + BIAS_HIGH : mag;
            end
            default: begin
                base  = {1'b0, mid};
                recip = '0;
                x     = '0;
            end
        endcase
        // negative numerators round toward minus infinity via the bias above
        full = x * recip;
        q    = full[RECIP_SHIFT +: TIME_W];
        return neg ? base - q : base + q;
    endfunction

endpackage

### rtl/core/rlts_core.sv
// LED state: time count, lit bits and deadlines, with their registered update
module rlts_core #(
    parameter int NUM_LEDS   = rlts_pkg::NUM_LEDS_DEF,
    parameter bit ACTIVE_LOW = rlts_pkg::ACTIVE_LOW_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            proc_en,
    input  rlts_pkg::item_t                 item,
    input  rlts_pkg::cfg_t                  cfg,
    output logic [rlts_pkg::OUT_LEDS-1:0]   lit_mask,
    output logic [rlts_pkg::OUT_LEDS-1:0]   pin_levels
);
    import rlts_pkg::*;

    localparam int DEPTH = (NUM_LEDS < IDX_SPAN) ? NUM_LEDS : IDX_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [TIME_W-1:0] time_reg, time_next;
    logic [DEPTH-1:0]  lit_reg, lit_next;
    logic [TIME_W-1:0] dark_reg [DEPTH];
    logic [TIME_W-1:0] rest_reg [DEPTH];

    logic              wr_en;
    logic              clear_all;
    logic              in_range;
    logic [AW-1:0]     addr;
    logic [TIME_W-1:0] dark_rd, rest_rd;
    logic [CNT_W-1:0]  lit_cnt;
    logic [TIME_W-1:0] on_len, rest_len;
    logic [TIME_W-1:0] dark_new, rest_new;
    logic [TIME_W-1:0] ovf_limit;

    // Operand fetch for the addressed LED
    assign in_range  = {1'b0, item.led_index} < CNT_W'(DEPTH);
    assign addr      = item.led_index[AW-1:0];
    assign dark_rd   = dark_reg[addr];
    assign rest_rd   = rest_reg[addr];
    assign lit_cnt   = CNT_W'($countones(lit_reg));
    assign ovf_limit = OVF_BASE - {1'b0, cfg.rest_max};

    // New deadlines if this LED lights
    assign on_len   = weigh_len(item.on_term, {5'b0, cfg.on_min}, {5'b0, cfg.on_mean});
    assign rest_len = weigh_len(item.rest_term, cfg.rest_min, cfg.rest_mean);
    assign dark_new = time_reg + on_len;
    assign rest_new = dark_new + rest_len;

    // Next state
    always_comb begin
        time_next = time_reg;
        lit_next  = lit_reg;
        wr_en     = 1'b0;
        clear_all = 1'b0;
        if (proc_en) begin
            unique case (item.op)
                OP_TICK: begin
                    time_next = time_reg + 1'b1;
                end
                OP_SERVICE: begin
                    if (in_range) begin
                        if (!lit_reg[addr]) begin
                            if (time_reg > rest_rd && item.trig_ok &&
                                lit_cnt < {1'b0, cfg.max_lit}) begin
                                lit_next[addr] = 1'b1;
                                wr_en          = 1'b1;
                            end
                        end else if (time_reg >= dark_rd || time_reg >= rest_rd) begin
                            lit_next[addr] = 1'b0;
                        end
                    end
                end
                OP_SWEEP_END: begin
                    if (time_reg > ovf_limit) begin
                        time_next = TIME_RESTART;
                        lit_next  = '0;
                        clear_all = 1'b1;
                    end
                end
                OP_UNUSED: begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= TIME_RESET;
            lit_reg  <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                dark_reg[i] <= '0;
                rest_reg[i] <= '0;
            end
        end else begin
            time_reg <= time_next;
            lit_reg  <= lit_next;
            if (clear_all) begin
                for (int i = 0; i < DEPTH; i++) begin
                    dark_reg[i] <= '0;
                    rest_reg[i] <= '0;
                end
            end else if (wr_en) begin
                dark_reg[addr] <= dark_new;
                rest_reg[addr] <= rest_new;
            end
        end
    end

    // Result view of the updated lit bits
    for (genvar g = 0; g < OUT_LEDS; g++) begin : g_out
        if (g < DEPTH) begin : g_led
            assign lit_mask[g] = lit_next[g];
        end else begin : g_none
            assign lit_mask[g] = 1'b0;
        end
        if (g < NUM_LEDS) begin : g_pin
            assign pin_levels[g] = ACTIVE_LOW ? ~lit_mask[g] : lit_mask[g];
        end else begin : g_nopin
            assign pin_levels[g] = 1'b0;
        end
    end

endmodule

### rtl/core/random_led_twinkle_scheduler.sv
// Path: an accepted item is registered in the input stage, then its result in the
// result register that drives m_tvalid. Throughput: one item per cycle while the
// result is taken; a stalled result holds the input stage, else items enter back to back.
// Reset (aresetn, synchronous, active low): time count 60, all LEDs dark,
// all deadlines 0, registers at their defaults, both stages empty.
module random_led_twinkle_scheduler #(
    parameter int NUM_LEDS   = rlts_pkg::NUM_LEDS_DEF,
    parameter bit ACTIVE_LOW = rlts_pkg::ACTIVE_LOW_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rlts_pkg::S_TDATA_W-1:0]    s_tdata,   // led_index, trigger_roll, on_roll,
                                                         // rest_roll, zero pad
    input  logic [rlts_pkg::OP_W-1:0]         s_tuser,   // op
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rlts_pkg::M_TDATA_W-1:0]    m_tdata,   // lit_mask, pin_levels, zero pad
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rlts_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rlts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import rlts_pkg::*;

    cfg_t               cfg_reg;
    item_t              item_reg, item_in;
    logic               in_valid_reg, in_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_LEDS-1:0] lit_mask_reg, pin_levels_reg;
    logic [OUT_LEDS-1:0] lit_mask_w, pin_levels_w;
    logic               s_accept;
    logic               advance;

    logic [IDX_W-1:0]   s_led_index;
    logic [ROLL_W-1:0]  s_trigger_roll, s_on_roll, s_rest_roll;

    // Input field unpack
    assign s_led_index    = s_tdata[IDX_W-1:0];
    assign s_trigger_roll = s_tdata[IDX_W +: ROLL_W];
    assign s_on_roll      = s_tdata[IDX_W+ROLL_W +: ROLL_W];
    assign s_rest_roll    = s_tdata[IDX_W+2*ROLL_W +: ROLL_W];

    // Handshake: input stage drains when the result register is free
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Input stage: trigger compare and the two duration multiplies
    always_comb begin
        item_in.op        = op_t'(s_tuser);
        item_in.led_index = s_led_index;
        item_in.trig_ok   = s_trigger_roll <= cfg_reg.trigger_threshold;
        item_in.on_term   = weigh_prod(s_on_roll, {5'b0, cfg_reg.on_min},
                                       {5'b0, cfg_reg.on_mean}, {5'b0, cfg_reg.on_max});
        item_in.rest_term = weigh_prod(s_rest_roll, cfg_reg.rest_min,
                                       cfg_reg.rest_mean, cfg_reg.rest_max);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_in;
        end
        if (advance) begin
            lit_mask_reg   <= lit_mask_w;
            pin_levels_reg <= pin_levels_w;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_min            <= ON_MIN_RST;
            cfg_reg.on_mean           <= ON_MEAN_RST;
            cfg_reg.on_max            <= ON_MAX_RST;
            cfg_reg.rest_min          <= REST_MIN_RST;
            cfg_reg.rest_mean         <= REST_MEAN_RST;
            cfg_reg.rest_max          <= REST_MAX_RST;
            cfg_reg.trigger_threshold <= TRIG_THR_RST;
            cfg_reg.max_lit           <= MAX_LIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ON_MIN:    cfg_reg.on_min            <= cfg_wdata[ON_W-1:0];
                REG_ON_MEAN:   cfg_reg.on_mean           <= cfg_wdata[ON_W-1:0];
                REG_ON_MAX:    cfg_reg.on_max            <= cfg_wdata[ON_W-1:0];
                REG_REST_MIN:  cfg_reg.rest_min          <= cfg_wdata[REST_W-1:0];
                REG_REST_MEAN: cfg_reg.rest_mean         <= cfg_wdata[REST_W-1:0];
                REG_REST_MAX:  cfg_reg.rest_max          <= cfg_wdata[REST_W-1:0];
                REG_TRIG_THR:  cfg_reg.trigger_threshold <= cfg_wdata[THR_W-1:0];
                REG_MAX_LIT:   cfg_reg.max_lit           <= cfg_wdata[MAXLIT_W-1:0];
            endcase
        end
    end

    // LED state and update
    rlts_core #(
        .NUM_LEDS   (NUM_LEDS),
        .ACTIVE_LOW (ACTIVE_LOW)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .proc_en    (advance),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .lit_mask   (lit_mask_w),
        .pin_levels (pin_levels_w)
    );

    // Result pack
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 2*OUT_LEDS)'(0), pin_levels_reg, lit_mask_reg};

endmodule

### rtl/core/rlts_checker.sv
`include "assert_macros.svh"

// Port-level checks on the scheduler
module rlts_checker #(
    parameter int NUM_LEDS   = rlts_pkg::NUM_LEDS_DEF,
    parameter bit ACTIVE_LOW = rlts_pkg::ACTIVE_LOW_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rlts_pkg::M_TDATA_W-1:0] m_tdata
);
    import rlts_pkg::*;

    localparam logic [OUT_LEDS-1:0] LED_MASK =
        (NUM_LEDS >= OUT_LEDS) ? {OUT_LEDS{1'b1}} : OUT_LEDS'((1 << NUM_LEDS) - 1);

    logic [OUT_LEDS-1:0] mask_w, pin_w;
    logic [OUT_LEDS-1:0] pin_exp;

    assign mask_w  = m_tdata[OUT_LEDS-1:0];
    assign pin_w   = m_tdata[OUT_LEDS +: OUT_LEDS];
    assign pin_exp = ACTIVE_LOW ? (~mask_w & LED_MASK) : mask_w;

    // a stalled result transaction holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata), "result changed while stalled")

    // with the result register empty the input side must be open
    `ASSERT_IMPL(a_in_open, aclk, aresetn, !m_tvalid, s_tready,
                 "input blocked with no result pending")

    // pin levels follow the lit mask; unused bits stay zero
    `ASSERT_IMPL(a_pin_map, aclk, aresetn, m_tvalid,
                 pin_w == pin_exp && (mask_w & ~LED_MASK) == '0 &&
                 m_tdata[M_TDATA_W-1:2*OUT_LEDS] == '0,
                 "pin levels do not match lit mask")

    // back-to-back results differ in one LED at most, unless a sweep cleared all
    `ASSERT_NEXT(a_one_change, aclk, aresetn, m_tvalid && m_tready,
                 !m_tvalid || $countones(mask_w ^ $past(mask_w)) <= 1 || mask_w == '0,
                 "more than one LED changed between results")

endmodule

bind random_led_twinkle_scheduler rlts_checker #(
    .NUM_LEDS   (NUM_LEDS),
    .ACTIVE_LOW (ACTIVE_LOW)
) u_rlts_checker (.*);
